// ----- rtl/bsm_pkg.sv -----
// Shared types, codes and constants for the bank switch mapper.
// Used by every module under rtl; depends on nothing else.
package bsm_pkg;

  localparam int CMDQ_DEPTH_DEF = 4;
  localparam int OUTQ_DEPTH_DEF = 2;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int ROM_W  = 21;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_TICK      = 2'd1,
    OP_CPU_READ  = 2'd2,
    OP_PPU_READ  = 2'd3
  } op_t;

  // Register selected by address bits 14, 13 and 0 of a CPU write.
  typedef enum logic [2:0] {
    REG_COMMAND   = 3'b000,
    REG_BANK_DATA = 3'b001,
    REG_MIRROR    = 3'b010,
    REG_UNUSED    = 3'b011,
    REG_LATCH     = 3'b100,
    REG_RELOAD    = 3'b101,
    REG_IRQ_OFF   = 3'b110,
    REG_IRQ_ON    = 3'b111
  } wreg_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_CMD,
    K_BANK,
    K_MIRROR,
    K_LATCH,
    K_RELOAD,
    K_IRQ_OFF,
    K_IRQ_ON,
    K_TICK,
    K_PRG_READ,
    K_CHR_READ
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_EXT_BANK_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_FOUR_MODE = 1'b1;

  // Command byte values, compared as whole bytes.
  localparam logic [7:0] CMD_CHR0 = 8'h00;
  localparam logic [7:0] CMD_CHR1 = 8'h0A;
  localparam logic [7:0] CMD_CHR2 = 8'h01;
  localparam logic [7:0] CMD_CHR3 = 8'h0B;
  localparam logic [7:0] CMD_CHR4 = 8'h02;
  localparam logic [7:0] CMD_CHR5 = 8'h03;
  localparam logic [7:0] CMD_CHR6 = 8'h04;
  localparam logic [7:0] CMD_CHR7 = 8'h05;
  localparam logic [7:0] CMD_PRG0 = 8'h06;
  localparam logic [7:0] CMD_PRG1 = 8'h07;
  localparam logic [7:0] CMD_PRG2 = 8'h08;
  localparam logic [7:0] CMD_PRG3 = 8'h09;

  localparam logic [7:0] PRG2_FIXED = 8'hFE;
  localparam logic [7:0] PRG3_FIXED = 8'hFF;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [12:0] offset;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [ROM_W-1:0] rom_address;
    logic [1:0]       mirroring;
    logic             irq_line;
  } res_t;

endpackage

// ----- rtl/bsm_fifo.sv -----
// Small first-in first-out queue of flat words, used between the decoder
// and the executor and again in front of the result port. Uses bsm_pkg.
module bsm_fifo
  import bsm_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH_DEF,
  parameter int WIDTH = $bits(item_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/bsm_front.sv -----
// Front end: classifies an incoming bus word into a work item for the
// executor (register write, tick, or slot lookup). Uses bsm_pkg.
module bsm_front
  import bsm_pkg::*;
(
  input  logic [1:0]        operation,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] data,
  output item_t             item
);

  wreg_t wreg;

  assign wreg = wreg_t'({address[14:13], address[0]});

  always_comb begin
    item.kind   = K_NONE;
    item.slot   = 3'd0;
    item.offset = address[12:0];
    item.data   = data;
    unique case (op_t'(operation))
      OP_CPU_WRITE: begin
        // Writes below the cartridge window have no effect.
        if (address[15]) begin
          unique case (wreg)
            REG_COMMAND:   item.kind = K_CMD;
            REG_BANK_DATA: item.kind = K_BANK;
            REG_MIRROR:    item.kind = K_MIRROR;
            REG_UNUSED:    item.kind = K_NONE;
            REG_LATCH:     item.kind = K_LATCH;
            REG_RELOAD:    item.kind = K_RELOAD;
            REG_IRQ_OFF:   item.kind = K_IRQ_OFF;
            REG_IRQ_ON:    item.kind = K_IRQ_ON;
            default:       item.kind = K_NONE;
          endcase
        end
      end
      OP_TICK: item.kind = K_TICK;
      OP_CPU_READ: begin
        if (address[15]) begin
          item.kind = K_PRG_READ;
          item.slot = {1'b0, address[14:13]};
        end
      end
      OP_PPU_READ: begin
        if (address[15:13] == 3'b000) begin
          item.kind = K_CHR_READ;
          item.slot = address[12:10];
        end
      end
      default: item.kind = K_NONE;
    endcase
  end

endmodule

// ----- rtl/bsm_back.sv -----
// Back end (uses bsm_pkg): holds the bank, mirroring and scanline counter state, carries
// out one classified item per cycle while the result queue has room, and forms its result word.
module bsm_back
  import bsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 item_take,
  input  logic                 res_full,
  output logic                 res_push,
  output res_t                 res
);

  logic       ext_bank_mode_r, mirror_four_mode_r;
  logic [7:0] command_r, command_nxt;
  logic [7:0] chr_bank_r [8];
  logic [7:0] chr_bank_nxt [8];
  logic [7:0] prg_bank_r [4];
  logic [7:0] prg_bank_nxt [4];
  logic [1:0] mirror_bits_r, mirror_bits_nxt;
  logic [7:0] irq_counter_r, irq_counter_nxt;
  logic [7:0] irq_latch_r, irq_latch_nxt;
  logic       reload_r, reload_nxt;
  logic       irq_enable_r, irq_enable_nxt;
  logic       irq_pending_r, irq_pending_nxt;
  logic [7:0] prg_sel;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;

  always_comb begin
    command_nxt     = command_r;
    chr_bank_nxt    = chr_bank_r;
    prg_bank_nxt    = prg_bank_r;
    mirror_bits_nxt = mirror_bits_r;
    irq_counter_nxt = irq_counter_r;
    irq_latch_nxt   = irq_latch_r;
    reload_nxt      = reload_r;
    irq_enable_nxt  = irq_enable_r;
    irq_pending_nxt = irq_pending_r;
    if (item_take) begin
      unique case (item.kind)
        K_CMD:    command_nxt = item.data;
        K_BANK: begin
          unique case (command_r)
            CMD_CHR0: begin
              if (ext_bank_mode_r) begin
                chr_bank_nxt[0] = item.data;
              end else begin
                chr_bank_nxt[0] = {item.data[7:1], 1'b0};
                chr_bank_nxt[1] = {item.data[7:1], 1'b1};
              end
            end
            CMD_CHR1: if (ext_bank_mode_r) chr_bank_nxt[1] = item.data;
            CMD_CHR2: begin
              if (ext_bank_mode_r) begin
                chr_bank_nxt[2] = item.data;
              end else begin
                chr_bank_nxt[2] = {item.data[7:1], 1'b0};
                chr_bank_nxt[3] = {item.data[7:1], 1'b1};
              end
            end
            CMD_CHR3: if (ext_bank_mode_r) chr_bank_nxt[3] = item.data;
            CMD_CHR4: chr_bank_nxt[4] = item.data;
            CMD_CHR5: chr_bank_nxt[5] = item.data;
            CMD_CHR6: chr_bank_nxt[6] = item.data;
            CMD_CHR7: chr_bank_nxt[7] = item.data;
            CMD_PRG0: prg_bank_nxt[0] = item.data;
            CMD_PRG1: prg_bank_nxt[1] = item.data;
            CMD_PRG2: if (ext_bank_mode_r) prg_bank_nxt[2] = item.data;
            CMD_PRG3: if (ext_bank_mode_r) prg_bank_nxt[3] = item.data;
            default: ;
          endcase
        end
        K_MIRROR:  mirror_bits_nxt = item.data[1:0];
        K_LATCH:   irq_latch_nxt = item.data;
        K_RELOAD:  reload_nxt = 1'b1;
        K_IRQ_OFF: begin
          irq_enable_nxt  = 1'b0;
          irq_pending_nxt = 1'b0;
        end
        K_IRQ_ON:  irq_enable_nxt = 1'b1;
        K_TICK: begin
          if (irq_counter_r == 8'd0 || reload_r) begin
            irq_counter_nxt = irq_latch_r;
            reload_nxt      = 1'b0;
          end else begin
            irq_counter_nxt = irq_counter_r - 8'd1;
          end
          // The interrupt fires only on a transition from nonzero to zero.
          if (irq_counter_r != 8'd0 && irq_counter_nxt == 8'd0 && irq_enable_r) begin
            irq_pending_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prg_sel = prg_bank_r[item.slot[1:0]];
    if (!ext_bank_mode_r && item.slot[1:0] == 2'd2) prg_sel = PRG2_FIXED;
    if (!ext_bank_mode_r && item.slot[1:0] == 2'd3) prg_sel = PRG3_FIXED;
  end

  always_comb begin
    res.rom_address = '0;
    priority if (item.kind == K_PRG_READ) begin
      res.rom_address = {prg_sel, item.offset};
    end else if (item.kind == K_CHR_READ) begin
      res.rom_address = {3'b000, chr_bank_r[item.slot], item.offset[9:0]};
    end
    res.mirroring = mirror_four_mode_r ? mirror_bits_nxt : {1'b0, mirror_bits_nxt[0]};
    res.irq_line  = irq_pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_bank_mode_r    <= 1'b1;
      mirror_four_mode_r <= 1'b0;
      command_r          <= '0;
      for (int i = 0; i < 8; i++) chr_bank_r[i] <= '0;
      prg_bank_r[0]      <= '0;
      prg_bank_r[1]      <= '0;
      prg_bank_r[2]      <= PRG2_FIXED;
      prg_bank_r[3]      <= PRG3_FIXED;
      mirror_bits_r      <= '0;
      irq_counter_r      <= '0;
      irq_latch_r        <= '0;
      reload_r           <= 1'b0;
      irq_enable_r       <= 1'b0;
      irq_pending_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EXT_BANK_MODE:    ext_bank_mode_r <= cfg_data;
          CFG_MIRROR_FOUR_MODE: mirror_four_mode_r <= cfg_data;
          default: ;
        endcase
      end
      command_r     <= command_nxt;
      chr_bank_r    <= chr_bank_nxt;
      prg_bank_r    <= prg_bank_nxt;
      mirror_bits_r <= mirror_bits_nxt;
      irq_counter_r <= irq_counter_nxt;
      irq_latch_r   <= irq_latch_nxt;
      reload_r      <= reload_nxt;
      irq_enable_r  <= irq_enable_nxt;
      irq_pending_r <= irq_pending_nxt;
    end
  end

endmodule

// ----- rtl/bank_switch_mapper_scanline_irq_unit.sv -----
// Top level of the bank switch mapper with scanline interrupt counter.
// Instantiates bsm_front, two bsm_fifo queues and bsm_back; uses bsm_pkg.
//
// Usage: the input side is a queue. Present in_operation, in_address and
// in_data with in_push; a word is taken on a clock edge where in_push is
// high and in_full is low. Each word yields exactly one result word, which
// appears on out_rom_address, out_mirroring and out_irq_line while out_empty
// is low, and is removed by raising out_pop.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// sets bank mode (index 0) and four-way mirroring mode (index 1); cfg_ready
// is always high, and writes belong between bursts of traffic.
// Flow: a word is decoded into the command queue at the edge it is taken
// and executed into the result queue once that queue has room, so it
// passes through the command queue and then the result queue before
// out_empty falls and the result can be popped.
// Throughput: one word per cycle, set by the executor, while the result queue has room.
// When the receiver stops popping, the result queue and then the command
// queue fill, after which in_full rises; nothing is dropped.
// Synchronous reset clears both queues and puts the mapper state at its
// power-on values (extended bank mode, vertical mirroring, IRQ idle).
module bank_switch_mapper_scanline_irq_unit
  import bsm_pkg::*;
#(
  parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF,
  parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_operation,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [ROM_W-1:0]     out_rom_address,
  output logic [1:0]           out_mirroring,
  output logic                 out_irq_line,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  item_t front_item, back_item;
  logic  cmdq_empty, item_take;
  logic  res_full, res_push;
  res_t  back_res, out_res;

  assign cfg_ready = 1'b1;

  bsm_front u_front (
    .operation (in_operation),
    .address   (in_address),
    .data      (in_data),
    .item      (front_item)
  );

  bsm_fifo #(
    .DEPTH (CMDQ_DEPTH),
    .WIDTH ($bits(item_t))
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (item_take),
    .rdata (back_item),
    .empty (cmdq_empty)
  );

  bsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!cmdq_empty),
    .item       (back_item),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  bsm_fifo #(
    .DEPTH (OUTQ_DEPTH),
    .WIDTH ($bits(res_t))
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_rom_address = out_res.rom_address;
  assign out_mirroring   = out_res.mirroring;
  assign out_irq_line    = out_res.irq_line;

endmodule
